FILE: hw/rtl/lift_bridge_sequencer_defines.svh
// Assertion macros shared by the lift bridge sequencer RTL.
`ifndef LIFT_BRIDGE_SEQUENCER_DEFINES_SVH
`define LIFT_BRIDGE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define LBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define LBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lbs_pkg.sv
// Types and constants shared by the lift bridge sequencer modules.
package lbs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_ROAD_WARN  = 3'd1,
        PH_BOAT_WARN  = 3'd2,
        PH_OPENING    = 3'd3,
        PH_OPEN       = 3'd4,
        PH_CLOSE_WARN = 3'd5,
        PH_CLOSING    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        DRV_STOP  = 2'd0,
        DRV_OPEN  = 2'd1,
        DRV_CLOSE = 2'd2
    } drive_t;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DETECT_CM     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAR_CM      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROAD_WARN_MS  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOAT_WARN_MS  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRAVEL_MS     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAR_HOLD_MS = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLASH_HALF_MS = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOTOR_DUTY    = 3'd7;

    localparam int CFG_DATA_BITS = 16;

    localparam logic [8:0]  RST_DETECT_CM     = 9'd50;
    localparam logic [8:0]  RST_CLEAR_CM      = 9'd70;
    localparam logic [15:0] RST_ROAD_WARN_MS  = 16'd10000;
    localparam logic [15:0] RST_BOAT_WARN_MS  = 16'd3000;
    localparam logic [15:0] RST_TRAVEL_MS     = 16'd4000;
    localparam logic [15:0] RST_CLEAR_HOLD_MS = 16'd8000;
    localparam logic [15:0] RST_FLASH_HALF_MS = 16'd500;
    localparam logic [7:0]  RST_MOTOR_DUTY    = 8'd200;

    typedef struct packed {
        logic [8:0]  detect_cm;
        logic [8:0]  clear_cm;
        logic [15:0] road_warn_ms;
        logic [15:0] boat_warn_ms;
        logic [15:0] travel_ms;
        logic [15:0] clear_hold_ms;
        logic [15:0] flash_half_ms;
        logic [7:0]  motor_duty;
    } cfg_t;

    typedef struct packed {
        logic   road_green;
        logic   road_yellow;
        logic   road_red;
        logic   boat_red;
        logic   boat_yellow;
        logic   boat_green;
        drive_t motor_drive;
        logic [7:0] motor_pwm;
        phase_t phase_code;
    } result_t;

endpackage

FILE: hw/rtl/lbs_cfg.sv
// Configuration register file of the lift bridge sequencer.
module lbs_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [lbs_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [lbs_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output lbs_pkg::cfg_t                      cfg
);
    import lbs_pkg::*;

    cfg_t cfg_reg;

    // Truncate write data to the width of the addressed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_cm     <= RST_DETECT_CM;
            cfg_reg.clear_cm      <= RST_CLEAR_CM;
            cfg_reg.road_warn_ms  <= RST_ROAD_WARN_MS;
            cfg_reg.boat_warn_ms  <= RST_BOAT_WARN_MS;
            cfg_reg.travel_ms     <= RST_TRAVEL_MS;
            cfg_reg.clear_hold_ms <= RST_CLEAR_HOLD_MS;
            cfg_reg.flash_half_ms <= RST_FLASH_HALF_MS;
            cfg_reg.motor_duty    <= RST_MOTOR_DUTY;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_DETECT_CM:     cfg_reg.detect_cm     <= wr_data[8:0];
                CFG_CLEAR_CM:      cfg_reg.clear_cm      <= wr_data[8:0];
                CFG_ROAD_WARN_MS:  cfg_reg.road_warn_ms  <= wr_data;
                CFG_BOAT_WARN_MS:  cfg_reg.boat_warn_ms  <= wr_data;
                CFG_TRAVEL_MS:     cfg_reg.travel_ms     <= wr_data;
                CFG_CLEAR_HOLD_MS: cfg_reg.clear_hold_ms <= wr_data;
                CFG_FLASH_HALF_MS: cfg_reg.flash_half_ms <= wr_data;
                CFG_MOTOR_DUTY:    cfg_reg.motor_duty    <= wr_data[7:0];
                default:           cfg_reg.motor_duty    <= cfg_reg.motor_duty;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/lbs_core.sv
// Phase sequencer state and per-tick step logic of the lift bridge sequencer.
module lbs_core #(
    parameter int TIME_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [31:0]     time_ms,
    input  logic [8:0]      distance_a,
    input  logic [8:0]      distance_b,
    input  lbs_pkg::cfg_t   cfg,
    output lbs_pkg::result_t res
);
    import lbs_pkg::*;

    `include "lift_bridge_sequencer_defines.svh"

    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] phase_start_reg, phase_start_next;
    logic [TIME_BITS-1:0] clear_start_reg, clear_start_next;
    logic [TIME_BITS-1:0] flash_last_reg, flash_last_next;
    logic                 clear_timing_reg, clear_timing_next;
    logic                 flash_level_reg, flash_level_next;
    logic                 byl_reg, byl_next;

    logic [TIME_BITS-1:0] now;
    logic                 phase_due_road, phase_due_boat, phase_due_travel;
    logic                 hold_due, flash_due;
    logic                 boat_seen, chan_clear;
    logic                 rg, ry, rr, br, bg;
    drive_t               drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            phase_start_reg  <= '0;
            clear_start_reg  <= '0;
            flash_last_reg   <= '0;
            clear_timing_reg <= 1'b0;
            flash_level_reg  <= 1'b0;
            byl_reg          <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            phase_start_reg  <= phase_start_next;
            clear_start_reg  <= clear_start_next;
            flash_last_reg   <= flash_last_next;
            clear_timing_reg <= clear_timing_next;
            flash_level_reg  <= flash_level_next;
            byl_reg          <= byl_next;
        end
    end

    // Elapsed times wrap at the time width.
    always_comb
    begin
        now              = TIME_BITS'(time_ms);
        phase_due_road   = (now - phase_start_reg) >= TIME_BITS'(cfg.road_warn_ms);
        phase_due_boat   = (now - phase_start_reg) >= TIME_BITS'(cfg.boat_warn_ms);
        phase_due_travel = (now - phase_start_reg) >= TIME_BITS'(cfg.travel_ms);
        hold_due         = (now - clear_start_reg) >= TIME_BITS'(cfg.clear_hold_ms);
        flash_due        = (now - flash_last_reg) >= TIME_BITS'(cfg.flash_half_ms);
        boat_seen        = (distance_a <= cfg.detect_cm) || (distance_b <= cfg.detect_cm);
        chan_clear       = (distance_a > cfg.clear_cm) && (distance_b > cfg.clear_cm);
    end

    always_comb
    begin
        phase_next        = phase_reg;
        phase_start_next  = phase_start_reg;
        clear_start_next  = clear_start_reg;
        flash_last_next   = flash_last_reg;
        clear_timing_next = clear_timing_reg;
        flash_level_next  = flash_level_reg;
        byl_next          = byl_reg;
        rg = 1'b0;
        ry = 1'b0;
        rr = 1'b1;
        br = 1'b1;
        bg = 1'b0;

        // Toggle the boat yellow flasher in the boat warning, opening and closing warning phases.
        if ((phase_reg == PH_BOAT_WARN) || (phase_reg == PH_OPENING)
            || (phase_reg == PH_CLOSE_WARN))
        begin
            if (flash_due)
            begin
                flash_level_next = !flash_level_reg;
                byl_next         = !flash_level_reg;
                flash_last_next  = now;
            end
        end

        case (phase_reg)
            PH_ROAD_WARN:
            begin
                rr       = 1'b0;
                ry       = 1'b1;
                byl_next = 1'b0;
                if (phase_due_road)
                begin
                    phase_start_next = now;
                    phase_next       = PH_BOAT_WARN;
                end
            end
            PH_BOAT_WARN:
            begin
                if (phase_due_boat)
                begin
                    phase_start_next = now;
                    phase_next       = PH_OPENING;
                    byl_next         = 1'b0;
                end
            end
            PH_OPENING:
            begin
                if (phase_due_travel)
                begin
                    br         = 1'b0;
                    bg         = 1'b1;
                    byl_next   = 1'b0;
                    phase_next = PH_OPEN;
                end
            end
            PH_OPEN:
            begin
                br       = 1'b0;
                bg       = 1'b1;
                byl_next = 1'b0;
                if (chan_clear)
                begin
                    if (!clear_timing_reg)
                    begin
                        clear_start_next  = now;
                        clear_timing_next = 1'b1;
                    end
                    else if (hold_due)
                    begin
                        phase_start_next  = now;
                        phase_next        = PH_CLOSE_WARN;
                        clear_timing_next = 1'b0;
                    end
                end
                else
                begin
                    clear_timing_next = 1'b0;
                end
            end
            PH_CLOSE_WARN:
            begin
                if (phase_due_boat)
                begin
                    phase_start_next = now;
                    phase_next       = PH_CLOSING;
                end
            end
            PH_CLOSING:
            begin
                // Boat yellow holds its last flash level while closing.
                if (phase_due_travel)
                begin
                    byl_next   = 1'b0;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                rr         = 1'b0;
                rg         = 1'b1;
                byl_next   = 1'b0;
                phase_next = PH_IDLE;
                if (boat_seen)
                begin
                    phase_start_next = now;
                    phase_next       = PH_ROAD_WARN;
                end
            end
        endcase

        // Motor follows the phase entered on this tick.
        if (phase_next == PH_OPENING)
        begin
            drive = DRV_OPEN;
        end
        else if (phase_next == PH_CLOSING)
        begin
            drive = DRV_CLOSE;
        end
        else
        begin
            drive = DRV_STOP;
        end
    end

    always_comb
    begin
        res.road_green  = rg;
        res.road_yellow = ry;
        res.road_red    = rr;
        res.boat_red    = br;
        res.boat_yellow = byl_next;
        res.boat_green  = bg;
        res.motor_drive = drive;
        res.motor_pwm   = (drive == DRV_STOP) ? 8'd0 : cfg.motor_duty;
        res.phase_code  = phase_next;
    end

    `LBS_ASSERT_IMP(a_clear_timing_open, clear_timing_reg, phase_reg == PH_OPEN,
        "clear hold timer running outside the open phase")
    `LBS_ASSERT_IMP(a_byl_phase, byl_reg,
        (phase_reg == PH_BOAT_WARN) || (phase_reg == PH_OPENING) ||
        (phase_reg == PH_CLOSE_WARN) || (phase_reg == PH_CLOSING),
        "boat yellow lamp lit in a phase that clears it")
    `LBS_ASSERT_NXT(a_phase_hold, !accept, $stable(phase_reg),
        "phase moved without an accepted tick")

endmodule

FILE: hw/rtl/lift_bridge_sequencer.sv
// Top level of the lift bridge sequencer: stream ports, config port, result register.
// An accepted tick's result is registered and appears on m_tdata in the next cycle.
// Throughput: one tick per cycle unless m_tready stalls; the phase step is a single
// combinational pass between the sequencer state registers and the result register.
// Reset (rst_n, asynchronous, active low): idle phase, timers and flasher cleared,
// registers at their defaults, no result pending.
module lift_bridge_sequencer #(
    parameter int TIME_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: time_ms[31:0], distance_a[40:32], distance_b[49:41], zero fill
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [55:0]                        s_tdata,
    // m_tdata: road_green[0], road_yellow[1], road_red[2], boat_red[3],
    // boat_yellow[4], boat_green[5], motor_drive[7:6], motor_pwm[15:8],
    // phase_code[18:16], zero fill
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,
    // Configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lbs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lbs_pkg::*;

    `include "lift_bridge_sequencer_defines.svh"

    cfg_t    cfg;
    result_t res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    accept;

    // Registers are always writable; the user must write them only while idle (not enforced here).
    assign cfg_ready = 1'b1;

    lbs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Take a new tick whenever the result register is empty or being drained
    // in this cycle, so ticks stream back to back.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    lbs_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .time_ms    (s_tdata[31:0]),
        .distance_a (s_tdata[40:32]),
        .distance_b (s_tdata[49:41]),
        .cfg        (cfg),
        .res        (res)
    );

    // Result register: load on accept, drop the valid flag once drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; it only loads with a transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;

    // Pack the result fields lowest bit first.
    assign m_tdata = {5'd0,
                      out_reg.phase_code,
                      out_reg.motor_pwm,
                      out_reg.motor_drive,
                      out_reg.boat_green,
                      out_reg.boat_yellow,
                      out_reg.boat_red,
                      out_reg.road_red,
                      out_reg.road_yellow,
                      out_reg.road_green};

    `LBS_ASSERT_NXT(a_accept_loads, accept, out_valid_reg,
        "accepted tick left no result pending")
    `LBS_ASSERT_IMP(a_drive_phase, out_valid_reg,
        ((out_reg.motor_drive == DRV_OPEN) == (out_reg.phase_code == PH_OPENING)) &&
        ((out_reg.motor_drive == DRV_CLOSE) == (out_reg.phase_code == PH_CLOSING)),
        "motor direction disagrees with phase")
    `LBS_ASSERT_IMP(a_road_green_idle, out_valid_reg && out_reg.road_green,
        (out_reg.phase_code == PH_IDLE) || (out_reg.phase_code == PH_ROAD_WARN),
        "road green shown outside idle")

endmodule
